>>> src/spq_pkg.sv
// Shared types and constants for the sorted max priority queue.
package spq_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_W     = $clog2(DEPTH + 1);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_W-1:0]            count_t;

	// Request codes carried on req_type.
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic   enq_en;
		logic   deq_en;
		value_t value;
	} cell_cmd_t;

endpackage

>>> src/sorted_max_priority_queue.sv
// Top level of the sorted max priority queue: count, control and the chain of cells.
// The result strobe done is registered: it rises in the cycle after a transaction is accepted.
// Throughput: one transaction per cycle; busy is always low because every cell
// compares and shifts in the same cycle.
// Reset empties the queue; stored values are left as they are and never read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_max_priority_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   req_type,
	input  spq_pkg::value_t        value_in,
	output logic                   done,
	output spq_pkg::status_t       status,
	output spq_pkg::value_t        value_out,
	output spq_pkg::count_t        occupancy
);
	import spq_pkg::*;

	count_t    count_q;
	logic      done_q;
	status_t   status_q;
	value_t    value_out_q;
	cell_cmd_t cmd;
	logic      full;
	logic      empty;
	logic      enq_ok;
	logic      deq_ok;
	logic      cell_valid [DEPTH];
	logic      cell_ge    [DEPTH];
	value_t    cell_val   [DEPTH];

	assign busy  = 1'b0;
	assign full  = (count_q == COUNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Decode the accepted transaction.
	assign enq_ok = start && (req_type == REQ_ENQ) && !full;
	assign deq_ok = start && (req_type == REQ_DEQ) && !empty;

	assign cmd.enq_en = enq_ok;
	assign cmd.deq_en = deq_ok;
	assign cmd.value  = value_in;

	// The chain of cells, each linked to both neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		value_t prev_val;
		value_t next_val;
		logic   prev_ge;

		assign cell_valid[i] = (COUNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_ge  = 1'b0;
			assign prev_val = value_in;
		end else begin : g_body
			assign prev_ge  = cell_ge[i-1];
			assign prev_val = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_val = cell_val[i];
		end else begin : g_inner
			assign next_val = cell_val[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.valid    (cell_valid[i]),
			.prev_ge  (prev_ge),
			.prev_val (prev_val),
			.next_val (next_val),
			.ge       (cell_ge[i]),
			.val      (cell_val[i])
		);
	end

	// Occupancy counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (enq_ok) begin
			count_q <= count_q + COUNT_W'(1);
		end else if (deq_ok) begin
			count_q <= count_q - COUNT_W'(1);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (start) begin
			if (req_type == REQ_ENQ) begin
				status_q <= full ? ST_FULL : ST_DONE;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_DONE;
			end
			value_out_q <= deq_ok ? cell_val[0] : '0;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;
	assign occupancy = count_q;

	// The count never goes past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	// A full refusal reports a full queue.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == COUNT_W'(DEPTH)))
		else $error("full status with queue not full");

	// An empty refusal reports an empty queue and no value.
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (occupancy == '0 && value_out == '0))
		else $error("empty status with data present");

	// A successful insert grows the count by one.
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		enq_ok |=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("insert did not grow the count");

endmodule

>>> src/spq_cell.sv
// One storage cell of the sorted chain: holds a value and shifts with its neighbors.
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic              valid,
	input  logic              prev_ge,
	input  spq_pkg::value_t   prev_val,
	input  spq_pkg::value_t   next_val,
	output logic              ge,
	output spq_pkg::value_t   val
);
	import spq_pkg::*;

	value_t val_q;

	// An empty cell always accepts; a filled one when the new value is not smaller.
	assign ge  = !valid || (cmd.value >= val_q);
	assign val = val_q;

	// Insert pushes toward the tail, removal pulls from the tail side.
	always_ff @(posedge clk) begin
		if (cmd.enq_en) begin
			if (ge) begin
				val_q <= prev_ge ? prev_val : cmd.value;
			end
		end else if (cmd.deq_en) begin
			val_q <= next_val;
		end
	end

endmodule

>>> verif/tb_sorted_max_priority_queue.sv
// Self-checking testbench for the sorted max priority queue.
`timescale 1ns / 100ps

module tb_sorted_max_priority_queue;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT  = 60000;
	localparam int RANDOM_ITEMS = 480;
	localparam int DRAIN_CYCLES = 4;
	localparam int PLAN_ROWS    = 22;

	// One result transaction as the block reports it.
	typedef struct packed {
		status_t status;
		value_t  value;
		count_t  occ;
	} queue_result_t;

	// One row of the directed plan; pinned rows carry a hand-written result.
	typedef struct packed {
		logic          req;
		value_t        val;
		logic          pinned;
		queue_result_t res;
	} plan_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    req_type;
	value_t  value_in;
	logic    done;
	status_t status;
	value_t  value_out;
	count_t  occupancy;

	// Hand-written result that travels with the request it belongs to.
	logic          pin_en;
	queue_result_t pin_res;

	// Shadow copy of the queue contents, kept in descending order.
	value_t held_vals [DEPTH];
	int     held_cnt;

	queue_result_t result_q [$];
	int            failures;
	int            results_seen;
	int            enq_cnt;
	int            deq_cnt;
	int            full_hits;
	int            empty_hits;
	int            cycle_cnt = 0;
	logic          idle_on;

	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{REQ_DEQ, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0000_0000, 5'd0}},
		'{REQ_ENQ, 32'h0000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 5'd1}},
		'{REQ_ENQ, 32'h7fff_ffff, 1'b1, '{ST_DONE,  32'h0000_0000, 5'd2}},
		'{REQ_ENQ, 32'h8000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 5'd3}},
		'{REQ_ENQ, 32'hffff_ffff, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0005, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0005, 1'b0, '0},
		'{REQ_DEQ, 32'hffff_ffff, 1'b1, '{ST_DONE,  32'h7fff_ffff, 5'd5}},
		'{REQ_ENQ, 32'h5555_5555, 1'b0, '0},
		'{REQ_ENQ, 32'haaaa_aaaa, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0001, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0002, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0003, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0004, 1'b0, '0},
		'{REQ_ENQ, 32'h7fff_ffff, 1'b0, '0},
		'{REQ_ENQ, 32'h8000_0000, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0005, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0000, 1'b0, '0},
		'{REQ_ENQ, 32'h1234_5678, 1'b0, '0},
		'{REQ_ENQ, 32'h0000_0001, 1'b1, '{ST_FULL,  32'h0000_0000, 5'd16}},
		'{REQ_DEQ, 32'h0000_0000, 1'b1, '{ST_DONE,  32'h7fff_ffff, 5'd15}},
		'{REQ_DEQ, 32'h0000_0000, 1'b0, '0}
	};

	sorted_max_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.value_in  (value_in),
		.done      (done),
		.status    (status),
		.value_out (value_out),
		.occupancy (occupancy)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request to the shadow queue and returns the result it should give.
	// A new value goes ahead of stored equal values.
	function automatic queue_result_t apply_request(input logic req, input value_t val);
		queue_result_t res;
		int            pos;
		res.status = ST_DONE;
		res.value  = '0;
		if (req == REQ_ENQ) begin
			if (held_cnt >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_cnt && val < held_vals[pos])
					pos++;
				for (int k = held_cnt; k > pos; k--)
					held_vals[k] = held_vals[k-1];
				held_vals[pos] = val;
				held_cnt++;
			end
		end else if (held_cnt == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.value = held_vals[0];
			for (int k = 0; k + 1 < held_cnt; k++)
				held_vals[k] = held_vals[k+1];
			held_cnt--;
		end
		res.occ = count_t'(held_cnt);
		return res;
	endfunction

	// Checks each result against the oldest expectation, then records newly
	// accepted transactions.
	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		queue_result_t predicted;
		if (!arst_n) begin
			held_cnt = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (result_q.size() == 0) begin
					$display("%0t: result with none expected: status %0d value %0d occ %0d",
						$time, status, value_out, occupancy);
					failures++;
				end else begin
					want = result_q.pop_front();
					if (status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, status);
						failures++;
					end
					if (value_out !== want.value) begin
						$display("%0t: value_out mismatch, expected %0d, actual %0d",
							$time, want.value, value_out);
						failures++;
					end
					if (occupancy !== want.occ) begin
						$display("%0t: occupancy mismatch, expected %0d, actual %0d",
							$time, want.occ, occupancy);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				predicted = apply_request(req_type, value_in);
				if (req_type == REQ_ENQ)
					enq_cnt++;
				else
					deq_cnt++;
				if (predicted.status == ST_FULL)
					full_hits++;
				if (predicted.status == ST_EMPTY)
					empty_hits++;
				result_q.push_back(pin_en ? pin_res : predicted);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Drives one request, after a random gap when idle_on is set, and returns at the edge that accepts it.
	task automatic issue_request(input logic req, input value_t val, input logic pinned,
		input queue_result_t res);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= req;
		value_in <= val;
		pin_en   <= pinned;
		pin_res  <= res;
		@(negedge clk);
		while (busy) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Picks a value to insert: extremes, a narrow band that makes ties, or anything.
	function automatic value_t pick_value();
		int     band;
		value_t v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hffff_ffff;
				endcase
			end
			1, 2, 3, 4: begin
				band = int'($urandom_range(0, 15)) - 8;
				v = value_t'(band);
			end
			default: v = value_t'($urandom);
		endcase
		return v;
	endfunction

	// Main sequence: reset, directed plan, random bursts, drain and verdict.
	initial begin
		int issued;
		int burst_len;
		int mode;
		int enq_pct;
		logic req;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		req_type     <= REQ_ENQ;
		value_in     <= '0;
		pin_en       <= 1'b0;
		pin_res      <= '0;
		failures     = 0;
		results_seen = 0;
		enq_cnt      = 0;
		deq_cnt      = 0;
		full_hits    = 0;
		empty_hits   = 0;
		idle_on      = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed plan: empty queue, extremes, ties, filling to full.
		for (int r = 0; r < PLAN_ROWS; r++)
			issue_request(directed_plan[r].req, directed_plan[r].val,
				directed_plan[r].pinned, directed_plan[r].res);

		// Random bursts that lean toward filling, draining or neither.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			burst_len = $urandom_range(10, 40);
			mode      = $urandom_range(0, 2);
			enq_pct   = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			idle_on   = ($urandom_range(0, 2) != 0);
			for (int b = 0; b < burst_len; b++) begin
				req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
				issue_request(req, pick_value(), 1'b0, '0);
				issued++;
			end
		end
		start <= 1'b0;

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d enqueues and %0d dequeues; %0d refused as full, %0d as empty.",
			enq_cnt, deq_cnt, full_hits, empty_hits);
		$display("Checked %0d results with %0d mismatches.", results_seen, failures);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> sorted_max_priority_queue.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_max_priority_queue.sv
verif/tb_sorted_max_priority_queue.sv
